// ===== rtl/sfr_pkg.sv =====
// Package with the shared types, register indexes and helpers of the find-and-replace core.
package sfr_pkg;

    // Byte lanes carried by the key and replacement text registers.
    localparam int TEXT_BYTES = 8;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_TEXT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd4;

    typedef logic [7:0] t_byte;

    // Input item: one source character or the string terminator.
    typedef struct packed {
        t_byte source_byte;
        logic  end_of_string;
    } t_in_item;

    // Result item: one emitted character or the end marker.
    typedef struct packed {
        t_byte output_byte;
        logic  has_byte;
        logic  is_last;
    } t_out_item;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_MATCH_CLEAR,
        OP_SHIFT_EMIT,
        OP_REPL_EMIT,
        OP_FLUSH_EMIT,
        OP_LAST
    } t_dp_op;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic near_full;
        logic match;
        logic fill_zero;
        logic repl_zero;
        logic repl_done;
        logic out_free;
    } t_dp_status;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPL,
        ST_FLUSH
    } t_ctl_state;

    // Byte idx of a text register; lanes past the register read as zero.
    function automatic t_byte text_byte(input logic [8*TEXT_BYTES-1:0] text,
                                        input logic [4:0] idx);
        t_byte b;
        b = '0;
        if (idx < 5'(TEXT_BYTES)) begin
            b = text[8*idx +: 8];
        end
        return b;
    endfunction

endpackage

// ===== rtl/string_find_and_replace_core.sv =====
// Top level of the streaming find-and-replace core.
//
// The core takes one source byte per transfer and replaces every greedy, left-to-right,
// non-overlapping occurrence of the key with the replacement text. A byte that does not
// complete a match, or that completes a mismatch, is taken while the output register is free,
// so plain text streams at one byte per cycle. A byte that completes a match is followed by
// the replacement, sent from the sequencer one byte per cycle through the single output
// register while that register is free. A terminator starts the flush: the window is sent
// one byte per cycle while the output register is free, and then the end marker is sent.
// Each result transfer that is held up by the consumer stalls the core. At most
// result_capacity - 1 bytes are sent per string; later bytes are dropped and only the end
// marker follows. Configuration writes are always accepted and must be made while the core
// is idle; writing key_length discards any pending window bytes.
module string_find_and_replace_core #(
    parameter int KEY_MAX  = 8,
    parameter int REPL_MAX = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sfr_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sfr_pkg::t_out_item              o_out
);
    import sfr_pkg::*;

    t_dp_op     s_op;
    t_dp_status s_status;

    assign o_cfg_ready = 1'b1;

    // Sequencing of window, replacement and flush operations.
    sfr_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_eos   (i_in.end_of_string),
        .o_in_ready (o_in_ready),
        .i_status   (s_status),
        .o_op       (s_op)
    );

    // Registers, window compare and output register.
    sfr_datapath #(
        .KEY_MAX  (KEY_MAX),
        .REPL_MAX (REPL_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_op        (s_op),
        .o_status    (s_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // A terminator transfer starts the flush, so no input is taken in the next cycle.
    a_eos_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.end_of_string) |=> !o_in_ready)
        else $error("input accepted right after a terminator");

    // Sequencer results are only issued when the output register can take them.
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_op == OP_REPL_EMIT || s_op == OP_FLUSH_EMIT || s_op == OP_LAST ||
         s_op == OP_SHIFT_EMIT) |-> s_status.out_free)
        else $error("result issued while output register is occupied");

    // An end marker never carries a character.
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.is_last) |-> (!o_out.has_byte && o_out.output_byte == 8'd0))
        else $error("end marker carries a character");

endmodule

// ===== rtl/sfr_datapath.sv =====
// Datapath of the find-and-replace core: registers, window, compare and output register.
module sfr_datapath #(
    parameter int KEY_MAX  = 8,
    parameter int REPL_MAX = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                     i_cfg_data,
    input  sfr_pkg::t_in_item               i_in,
    input  sfr_pkg::t_dp_op                 i_op,
    output sfr_pkg::t_dp_status             o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sfr_pkg::t_out_item              o_out
);
    import sfr_pkg::*;

    localparam int KLEN_W = $clog2(KEY_MAX + 1);
    localparam int IDX_W  = (REPL_MAX > 1) ? $clog2(REPL_MAX) : 1;

    // Configuration registers.
    logic [63:0] r_key_text;
    logic [3:0]  r_key_length;
    logic [63:0] r_repl_text;
    logic [3:0]  r_repl_length;
    logic [15:0] r_capacity;

    // Working state.
    t_byte             r_win [KEY_MAX];
    logic [KLEN_W-1:0] r_fill;
    logic [15:0]       r_emitted;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [5:0] key_len_eff;
    logic [5:0] repl_len_eff;
    t_byte      cand [KEY_MAX];
    t_byte      nxt_shift [KEY_MAX];
    t_byte      nxt_flush [KEY_MAX];
    logic [KEY_MAX-1:0] lane_ok;
    logic       near_full;
    logic       match;
    logic       can_emit;
    logic       out_free;
    t_byte      repl_byte;
    logic       emit_req;
    logic       emit_byte;
    t_out_item  emit_item;

    // Effective key and replacement lengths after clamping.
    always_comb begin
        key_len_eff = {2'b00, r_key_length};
        if (key_len_eff == 6'd0) begin
            key_len_eff = 6'd1;
        end
        if (key_len_eff > 6'(KEY_MAX)) begin
            key_len_eff = 6'(KEY_MAX);
        end
        repl_len_eff = {2'b00, r_repl_length};
        if (repl_len_eff > 6'(REPL_MAX)) begin
            repl_len_eff = 6'(REPL_MAX);
        end
    end

    // Per-lane view of the window with the incoming byte placed at the fill point.
    for (genvar j = 0; j < KEY_MAX; j++) begin : g_lane
        assign cand[j] = (j == int'(r_fill)) ? i_in.source_byte : r_win[j];
        assign lane_ok[j] = (6'(j) >= key_len_eff) ||
                            (cand[j] == text_byte(r_key_text, 5'(j)));
        if (j < KEY_MAX - 1) begin : g_up
            assign nxt_shift[j] = cand[j+1];
            assign nxt_flush[j] = r_win[j+1];
        end else begin : g_top
            assign nxt_shift[j] = r_win[j];
            assign nxt_flush[j] = r_win[j];
        end
    end

    assign near_full = (6'(r_fill) + 6'd1) >= key_len_eff;
    assign match     = &lane_ok;
    assign can_emit  = ({1'b0, r_emitted} + 17'd1) < {1'b0, r_capacity};
    assign out_free  = !r_out_valid || i_out_ready;
    assign repl_byte = text_byte(r_repl_text, 5'(r_idx));

    // Status toward the controller.
    always_comb begin
        o_status.near_full = near_full;
        o_status.match     = match;
        o_status.fill_zero = (r_fill == '0);
        o_status.repl_zero = (repl_len_eff == 6'd0);
        o_status.repl_done = ((6'(r_idx) + 6'd1) == repl_len_eff);
        o_status.out_free  = out_free;
    end

    // Result selection for the current operation; bytes past capacity are dropped.
    always_comb begin
        emit_item.output_byte = '0;
        emit_item.has_byte    = 1'b1;
        emit_item.is_last     = 1'b0;
        emit_byte             = 1'b0;
        emit_req              = 1'b0;
        case (i_op)
            OP_SHIFT_EMIT: begin
                emit_item.output_byte = cand[0];
                emit_byte             = can_emit;
            end
            OP_REPL_EMIT: begin
                emit_item.output_byte = repl_byte;
                emit_byte             = can_emit;
            end
            OP_FLUSH_EMIT: begin
                emit_item.output_byte = r_win[0];
                emit_byte             = can_emit;
            end
            OP_LAST: begin
                emit_item.has_byte = 1'b0;
                emit_item.is_last  = 1'b1;
                emit_req           = 1'b1;
            end
            default: begin
                emit_byte = 1'b0;
            end
        endcase
        if (emit_byte) begin
            emit_req = 1'b1;
        end
    end

    // Configuration and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_text    <= '0;
            r_key_length  <= 4'd1;
            r_repl_text   <= '0;
            r_repl_length <= 4'd0;
            r_capacity    <= 16'hFFFF;
            r_fill        <= '0;
            r_emitted     <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // A new key length discards the pending window.
            if (i_cfg_we && (i_cfg_index == CFG_KEY_LENGTH)) begin
                r_fill <= '0;
            end else begin
                case (i_op)
                    OP_PUSH:        r_fill <= r_fill + 1'b1;
                    OP_MATCH_CLEAR: r_fill <= '0;
                    OP_FLUSH_EMIT:  r_fill <= r_fill - 1'b1;
                    OP_LAST:        r_fill <= '0;
                    default:        r_fill <= r_fill;
                endcase
            end

            if (i_op == OP_LAST) begin
                r_emitted <= '0;
            end else if (emit_byte) begin
                r_emitted <= r_emitted + 16'd1;
            end

            if (i_op == OP_MATCH_CLEAR) begin
                r_idx <= '0;
            end else if (i_op == OP_REPL_EMIT) begin
                r_idx <= r_idx + 1'b1;
            end

            if (emit_req) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_TEXT:    r_key_text <= i_cfg_data;
                    CFG_KEY_LENGTH:  r_key_length <= i_cfg_data[3:0];
                    CFG_REPL_TEXT:   r_repl_text <= i_cfg_data;
                    CFG_REPL_LENGTH: r_repl_length <= i_cfg_data[3:0];
                    CFG_CAPACITY:    r_capacity <= i_cfg_data[15:0];
                    default:         r_capacity <= r_capacity;
                endcase
            end
        end
    end

    // Window lanes and output payload.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < KEY_MAX; j++) begin
            case (i_op)
                OP_PUSH: begin
                    if (j == int'(r_fill)) begin
                        r_win[j] <= i_in.source_byte;
                    end
                end
                OP_SHIFT_EMIT: r_win[j] <= nxt_shift[j];
                OP_FLUSH_EMIT: r_win[j] <= nxt_flush[j];
                default:       r_win[j] <= r_win[j];
            endcase
        end
        if (emit_req) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/sfr_controller.sv =====
// Controller state machine of the find-and-replace core.
module sfr_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_eos,
    output logic                 o_in_ready,
    input  sfr_pkg::t_dp_status  i_status,
    output sfr_pkg::t_dp_op      o_op
);
    import sfr_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath operation.
    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_in_eos) begin
                        n_state = ST_FLUSH;
                    end else if (!i_status.near_full) begin
                        o_op = OP_PUSH;
                    end else if (i_status.match) begin
                        o_op = OP_MATCH_CLEAR;
                        if (!i_status.repl_zero) begin
                            n_state = ST_REPL;
                        end
                    end else begin
                        o_op = OP_SHIFT_EMIT;
                    end
                end
            end
            ST_REPL: begin
                if (i_status.out_free) begin
                    o_op = OP_REPL_EMIT;
                    if (i_status.repl_done) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    if (i_status.fill_zero) begin
                        o_op    = OP_LAST;
                        n_state = ST_IDLE;
                    end else begin
                        o_op = OP_FLUSH_EMIT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
